// File: hdl/hmmf_pkg.sv
// hmmf_pkg: shared types and constants of the scaled hmm forward block
// no dependencies; read first by every other file of the block but hmmf_ram

package hmmf_pkg;

  // input item op codes
  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_LOAD_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TRANS = 2'd1;
  localparam logic [OP_W-1:0] OP_EVIDENCE   = 2'd2;

  // payload widths fixed by the item format
  localparam int unsigned IDX_W = 4;
  localparam int unsigned Q15_W = 16;
  localparam logic [Q15_W-1:0] Q15_ONE = 16'd32768;

  // running sum of unnormalized messages
  localparam int unsigned SUM_W = 20;
  localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;

  // divider: (pending * 2^15 + sum / 2) / sum, quotient below 2^16
  localparam int unsigned DIVD_W    = 31;
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned DIV_CNT_W = 5;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned NUM_STATES_W = 5;
  localparam logic [NUM_STATES_W-1:0] NUM_STATES_RESET = 5'd16;
  localparam logic REG_NUM_STATES = 1'b0;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [SUM_W-1:0]  divisor;
  } hmmf_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } hmmf_div_rsp_t;

endpackage

// File: hdl/hmmf_in_if.sv
// hmmf_in_if: input item channel, valid/ready handshake with load and evidence payload
// depends on hmmf_pkg

interface hmmf_in_if;
  import hmmf_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  logic [Q15_W-1:0] value;
  logic             first_step;

  modport source (output valid, op, row_index, col_index, value, first_step, input ready);
  modport sink   (input valid, op, row_index, col_index, value, first_step, output ready);
endinterface

// File: hdl/hmmf_out_if.sv
// hmmf_out_if: result item channel, valid/ready handshake with normalized message payload
// depends on hmmf_pkg

interface hmmf_out_if;
  import hmmf_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] state_index;
  logic [Q15_W-1:0] fwd_prob;
  logic [Q15_W-1:0] marg_prob;
  logic             zero_sum;
  logic             last;

  modport source (output valid, state_index, fwd_prob, marg_prob, zero_sum, last, input ready);
  modport sink   (input valid, state_index, fwd_prob, marg_prob, zero_sum, last, output ready);
endinterface

// File: hdl/hmmf_ram.sv
// hmmf_ram: generic single-write, single-read memory with registered read data
// no dependencies

module hmmf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/hmmf_div.sv
// hmmf_div: restoring divider, one quotient bit per cycle, sixteen quotient bits per divide
// depends on hmmf_pkg; caller guarantees the quotient fits in sixteen bits

module hmmf_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hmmf_pkg::hmmf_div_req_t req_i,
  output hmmf_pkg::hmmf_div_rsp_t rsp_o
);
  import hmmf_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]     rem_q;
  logic [SUM_W-1:0]     dsr_q;
  logic [QUO_W-1:0]     dvd_q;
  logic [QUO_W-1:0]     quo_q;
  logic [SUM_W:0]       trial;
  logic [SUM_W:0]       diff;
  logic                 ge;
  logic                 step;

  assign trial = {rem_q, dvd_q[QUO_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});
  assign step  = busy_q && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(QUO_W);
    end else if (step) begin
      cnt_q <= cnt_q - 1'b1;
    end else if (busy_q) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= SUM_W'(req_i.dividend[DIVD_W-1:QUO_W]);
      dvd_q <= req_i.dividend[QUO_W-1:0];
      dsr_q <= req_i.divisor;
    end else if (step) begin
      rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign rsp_o.done     = busy_q && (cnt_q == '0);
  assign rsp_o.quotient = quo_q;

endmodule

// File: hdl/hmm_forward_normalized.sv
// Scaled hmm forward pass. Load items (op 0, op 1) write one entry of the initial
// vector or one transition entry. An evidence item (op 2) for state k builds
// that state's unnormalized message: on a first step from the initial vector,
// otherwise by a K-term dot product of the previous normalized message with
// transition column k through the single shared multiplier. The evidence item for
// state K-1 closes the step: each of the K pending messages is divided by the
// running sum in the serial divider and sent as one result item, so the closing
// item holds the input until the last result of the step is registered. Results
// go out through an output register; the next item is taken while the last result
// of a step still waits. All stores are memories without reset; reading an entry
// never written is undefined.
// depends on hmmf_pkg, hmmf_in_if, hmmf_out_if, hmmf_ram, hmmf_div

module hmm_forward_normalized #(
  parameter int unsigned MAX_STATES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hmmf_pkg::PADDR_W-1:0]  paddr,
  input  logic [hmmf_pkg::PDATA_W-1:0]  pwdata,
  output logic [hmmf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  hmmf_in_if.sink                       in_i,
  hmmf_out_if.source                    out_o
);
  import hmmf_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_STATES);
  localparam int unsigned CW    = $clog2(MAX_STATES + 1);
  localparam int unsigned TD    = MAX_STATES * MAX_STATES;
  localparam int unsigned TW    = $clog2(TD);
  localparam int unsigned DW    = 31 + IW;   // dot product, Q.30 summed over K terms
  localparam int unsigned BW    = DW - 16;   // wide multiplier operand
  localparam int unsigned TOT_W = DW + 17;
  localparam int unsigned MR_W  = TOT_W - 30;

  // sequencer state codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_INITD = 4'd2;
  localparam logic [3:0] S_DOT   = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_LO    = 4'd5;
  localparam logic [3:0] S_HI    = 4'd6;
  localparam logic [3:0] S_MSG   = 4'd7;
  localparam logic [3:0] S_NRD   = 4'd8;
  localparam logic [3:0] S_NDIV  = 4'd9;
  localparam logic [3:0] S_NWAIT = 4'd10;
  localparam logic [3:0] S_NOUT  = 4'd11;

  logic [3:0]              state_q, state_d;
  logic [IW-1:0]           idx_q, idx_d;
  logic [IW-1:0]           col_q;
  logic [Q15_W-1:0]        val_q;
  logic [DW-1:0]           dot_q;
  logic [DW-1:0]           prod_q;
  logic [DW-1:0]           lo_q;
  logic [Q15_W-1:0]        f_q;
  logic                    rd_vld_q;
  logic                    acc_vld_q;
  logic [SUM_W-1:0]        sum_q;
  logic [NUM_STATES_W-1:0] num_states_q;

  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_idx_q;
  logic [Q15_W-1:0]        out_fwd_q;
  logic [Q15_W-1:0]        out_marg_q;
  logic                    out_zero_q;
  logic                    out_last_q;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic reg_hit;
  logic cfg_we;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_NUM_STATES);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? PDATA_W'(num_states_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q <= NUM_STATES_RESET;
    end else if (cfg_we) begin
      num_states_q <= pwdata[NUM_STATES_W-1:0];
    end
  end

  // states in use, clamped to 1..MAX_STATES
  logic [CW-1:0] k_use;
  logic [CW-1:0] k_last;

  always_comb begin
    if (num_states_q == '0) begin
      k_use = CW'(1);
    end else if (8'(num_states_q) > 8'(MAX_STATES)) begin
      k_use = CW'(MAX_STATES);
    end else begin
      k_use = CW'(num_states_q);
    end
  end

  assign k_last = k_use - 1'b1;

  // ---------------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------------
  logic             in_ready;
  logic             in_acc;
  logic             col_ok;
  logic             row_ok;
  logic             ev_go;
  logic [Q15_W-1:0] val_sat;

  assign in_ready    = (state_q == S_IDLE);
  assign in_i.ready  = in_ready;
  assign in_acc      = in_i.valid && in_ready;
  assign col_ok      = (8'(in_i.col_index) < 8'(MAX_STATES));
  assign row_ok      = (8'(in_i.row_index) < 8'(MAX_STATES));
  assign val_sat     = (in_i.value > Q15_ONE) ? Q15_ONE : in_i.value;
  // evidence beyond the states in use is dropped
  assign ev_go       = in_acc && (in_i.op == OP_EVIDENCE) &&
                       (8'(in_i.col_index) < 8'(k_use));

  // ---------------------------------------------------------------------------
  // stores
  // ---------------------------------------------------------------------------
  logic             init_we;
  logic [Q15_W-1:0] init_rdata;
  logic             trans_we;
  logic [TW-1:0]    trans_waddr;
  logic [TW-1:0]    trans_raddr;
  logic [Q15_W-1:0] trans_rdata;
  logic             prev_we;
  logic [Q15_W-1:0] prev_rdata;
  logic             pend_we;
  logic [Q15_W-1:0] pend_rdata;
  logic [Q15_W-1:0] msg;

  assign init_we     = in_acc && (in_i.op == OP_LOAD_INIT) && col_ok;
  assign trans_we    = in_acc && (in_i.op == OP_LOAD_TRANS) && col_ok && row_ok;
  assign trans_waddr = TW'(in_i.row_index) * TW'(MAX_STATES) + TW'(in_i.col_index);
  // row idx of column col during the dot product
  assign trans_raddr = TW'(idx_q) * TW'(MAX_STATES) + TW'(col_q);

  hmmf_ram #(.WIDTH(Q15_W), .DEPTH(MAX_STATES)) u_init_ram (
    .clk_i   (clk_i),
    .we_i    (init_we),
    .waddr_i (IW'(in_i.col_index)),
    .wdata_i (val_sat),
    .raddr_i (col_q),
    .rdata_o (init_rdata)
  );

  hmmf_ram #(.WIDTH(Q15_W), .DEPTH(TD)) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (trans_we),
    .waddr_i (trans_waddr),
    .wdata_i (val_sat),
    .raddr_i (trans_raddr),
    .rdata_o (trans_rdata)
  );

  hmmf_ram #(.WIDTH(Q15_W), .DEPTH(MAX_STATES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (idx_q),
    .wdata_i (f_q),
    .raddr_i (idx_q),
    .rdata_o (prev_rdata)
  );

  hmmf_ram #(.WIDTH(Q15_W), .DEPTH(MAX_STATES)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (col_q),
    .wdata_i (msg),
    .raddr_i (idx_q),
    .rdata_o (pend_rdata)
  );

  // ---------------------------------------------------------------------------
  // shared multiplier, registered product
  //   dot phase: prev[i] * trans[i][col]
  //   scale phase: evidence * dot, low 16 bits then high bits
  // ---------------------------------------------------------------------------
  logic [Q15_W-1:0] mul_a;
  logic [BW-1:0]    mul_b;
  logic [DW-1:0]    mul_p;

  always_comb begin
    unique case (state_q)
      S_LO: begin
        mul_a = val_q;
        mul_b = BW'(dot_q[15:0]);
      end
      S_HI: begin
        mul_a = val_q;
        mul_b = dot_q[DW-1:16];
      end
      default: begin
        mul_a = prev_rdata;
        mul_b = BW'(trans_rdata);
      end
    endcase
  end

  assign mul_p = {{BW{1'b0}}, mul_a} * {{Q15_W{1'b0}}, mul_b};

  // message = (ev * dot + 2^29) >> 30, saturated at one
  logic [TOT_W-1:0] total;
  logic [MR_W-1:0]  msg_raw;
  logic [SUM_W:0]   sum_acc;
  logic [SUM_W-1:0] sum_next;

  assign total    = (TOT_W'(prod_q) << 16) + TOT_W'(lo_q) + (TOT_W'(1) << 29);
  assign msg_raw  = total[TOT_W-1:30];
  assign msg      = (msg_raw > MR_W'(Q15_ONE)) ? Q15_ONE : Q15_W'(msg_raw);
  assign sum_acc  = {1'b0, sum_q} + (SUM_W+1)'(msg);
  assign sum_next = (sum_acc > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_acc[SUM_W-1:0];

  // ---------------------------------------------------------------------------
  // normalization divider
  // ---------------------------------------------------------------------------
  hmmf_div_req_t div_req;
  hmmf_div_rsp_t div_rsp;
  logic          sum_zero;
  logic          div_bypass;

  assign sum_zero   = (sum_q == '0);
  // pending above the sum saturates to one, so the divide is skipped
  assign div_bypass = sum_zero || (SUM_W'(pend_rdata) > sum_q);

  assign div_req.start    = (state_q == S_NDIV) && !div_bypass;
  assign div_req.dividend = (DIVD_W'(pend_rdata) << 15) + DIVD_W'(sum_q >> 1);
  assign div_req.divisor  = sum_q;

  hmmf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic out_free;
  logic out_load;
  logic at_last_idx;

  assign out_free    = !out_valid_q || out_o.ready;
  assign at_last_idx = (CW'(idx_q) == k_last);
  assign out_load    = (state_q == S_NOUT) && out_free;
  assign pend_we     = (state_q == S_MSG);
  assign prev_we     = out_load;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (ev_go) begin
          idx_d   = '0;
          state_d = in_i.first_step ? S_INIT : S_DOT;
        end
      end
      S_INIT:  state_d = S_INITD;
      S_INITD: state_d = S_LO;
      S_DOT: begin
        if (at_last_idx) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !acc_vld_q) begin
          state_d = S_LO;
        end
      end
      S_LO: state_d = S_HI;
      S_HI: state_d = S_MSG;
      S_MSG: begin
        // the element for state K-1 closes the step
        if (CW'(col_q) == k_last) begin
          idx_d   = '0;
          state_d = S_NRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_NRD:  state_d = S_NDIV;
      S_NDIV: state_d = div_bypass ? S_NOUT : S_NWAIT;
      S_NWAIT: begin
        if (div_rsp.done) begin
          state_d = S_NOUT;
        end
      end
      S_NOUT: begin
        if (out_free) begin
          if (at_last_idx) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_NRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      acc_vld_q   <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rd_vld_q  <= (state_q == S_DOT);
      acc_vld_q <= rd_vld_q;
      if (state_q == S_MSG) begin
        sum_q <= sum_next;
      end else if (out_load && at_last_idx) begin
        sum_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (ev_go) begin
      col_q <= IW'(in_i.col_index);
      val_q <= val_sat;
    end
    if (ev_go) begin
      dot_q <= '0;
    end else if (state_q == S_INITD) begin
      // first step: init << 15 so that the common scaling gives (ev * init + 2^14) >> 15
      dot_q <= DW'(init_rdata) << 15;
    end else if (acc_vld_q) begin
      dot_q <= dot_q + prod_q;
    end
    if (state_q == S_HI) begin
      lo_q <= prod_q;
    end
    if (state_q == S_NDIV) begin
      f_q <= sum_zero ? '0 : Q15_ONE;
    end else if ((state_q == S_NWAIT) && div_rsp.done) begin
      f_q <= div_rsp.quotient;
    end
    if (out_load) begin
      out_idx_q  <= IDX_W'(idx_q);
      out_fwd_q  <= f_q;
      out_marg_q <= (sum_q > SUM_W'(Q15_ONE)) ? Q15_ONE : Q15_W'(sum_q);
      out_zero_q <= sum_zero;
      out_last_q <= at_last_idx;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.state_index = out_idx_q;
  assign out_o.fwd_prob    = out_fwd_q;
  assign out_o.marg_prob   = out_marg_q;
  assign out_o.zero_sum    = out_zero_q;
  assign out_o.last        = out_last_q;

endmodule

// File: hdl/hmmf_chk.sv
// hmmf_chk: port-level checks of the scaled hmm forward block, bound to its top level
// depends on hmmf_pkg and hmm_forward_normalized

module hmmf_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hmmf_pkg::IDX_W-1:0]  state_index,
  input logic [hmmf_pkg::Q15_W-1:0]  fwd_prob,
  input logic [hmmf_pkg::Q15_W-1:0]  marg_prob,
  input logic                        zero_sum,
  input logic                        last
);
  import hmmf_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(fwd_prob) && $stable(state_index) &&
      $stable(marg_prob) && $stable(zero_sum) && $stable(last))
    else $error("result item changed while stalled");

  a_zero_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && zero_sum |-> fwd_prob == '0)
    else $error("nonzero message on a zero-sum step");

  a_zero_marg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> zero_sum == (marg_prob == '0))
    else $error("zero_sum flag disagrees with marginal");

  a_q15_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> fwd_prob <= Q15_ONE && marg_prob <= Q15_ONE)
    else $error("result above one");

  // mid-step results come out only while the input is held off
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !last |-> !in_ready)
    else $error("input taken while a step is still being emitted");

endmodule

bind hmm_forward_normalized hmmf_chk u_hmmf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .state_index (out_o.state_index),
  .fwd_prob    (out_o.fwd_prob),
  .marg_prob   (out_o.marg_prob),
  .zero_sum    (out_o.zero_sum),
  .last        (out_o.last)
);

// File: tb/hmmf_forward_checker.sv
// hmmf_forward_checker: watches the register port and both item channels of the scaled
// hmm forward block, predicts every result item and compares it field by field
// depends on hmmf_pkg, hmmf_in_if, hmmf_out_if

module hmmf_forward_checker #(
  parameter int unsigned                  MAX_STATES      = 16,
  parameter logic [hmmf_pkg::PADDR_W-1:0] NUM_STATES_ADDR = '0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [hmmf_pkg::PADDR_W-1:0] paddr,
  input  logic [hmmf_pkg::PDATA_W-1:0] pwdata,
  hmmf_in_if                           in_mon_i,
  hmmf_out_if                          out_mon_i,
  output int unsigned                  error_count_o,
  output int unsigned                  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hmmf_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] state_index;
    logic [Q15_W-1:0] fwd_prob;
    logic [Q15_W-1:0] marg_prob;
    logic             zero_sum;
    logic             last;
  } fwd_result_t;

  logic [Q15_W-1:0]        init_prob   [MAX_STATES];
  logic [Q15_W-1:0]        trans_prob  [MAX_STATES][MAX_STATES];
  logic [Q15_W-1:0]        prev_msg    [MAX_STATES];
  logic [Q15_W-1:0]        pending_msg [MAX_STATES];
  logic [SUM_W-1:0]        msg_sum;
  logic [NUM_STATES_W-1:0] num_states;
  fwd_result_t             expected_msgs [$];
  int unsigned             mismatches;

  function automatic logic [Q15_W-1:0] sat_q15(input logic [63:0] v);
    return (v > 64'(Q15_ONE)) ? Q15_ONE : v[Q15_W-1:0];
  endfunction

  function automatic int unsigned active_states();
    if (num_states == 0) return 1;
    if (num_states > MAX_STATES) return MAX_STATES;
    return num_states;
  endfunction

  // one accepted item: update the stores, and on the closing element
  // queue the normalized messages of the whole step
  function automatic void advance_forward(input logic [OP_W-1:0] op,
                                          input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col,
                                          input logic [Q15_W-1:0] value,
                                          input logic first);
    logic [Q15_W-1:0] v;
    logic [63:0]      dot;
    logic [63:0]      msg;
    logic [63:0]      total;
    int unsigned      k;
    fwd_result_t      r;
    v = sat_q15(64'(value));
    k = active_states();
    if (col >= MAX_STATES) return;
    case (op)
      OP_LOAD_INIT: begin
        init_prob[col] = v;
      end
      OP_LOAD_TRANS: begin
        if (row < MAX_STATES) trans_prob[row][col] = v;
      end
      OP_EVIDENCE: begin
        if (col >= k) return;
        if (first) begin
          msg = (64'(v) * init_prob[col] + 64'd16384) >> 15;
        end else begin
          dot = '0;
          for (int i = 0; i < k; i++) dot += 64'(prev_msg[i]) * trans_prob[i][col];
          msg = (64'(v) * dot + (64'd1 << 29)) >> 30;
        end
        pending_msg[col] = sat_q15(msg);
        total = 64'(msg_sum) + pending_msg[col];
        msg_sum = (total > 64'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
        if (col != k - 1) return;
        total = 64'(msg_sum);
        for (int i = 0; i < k; i++) begin
          r.state_index = IDX_W'(i);
          r.fwd_prob    = (total == 0) ? '0 :
                          sat_q15((64'(pending_msg[i]) * Q15_ONE + total / 2) / total);
          r.marg_prob   = sat_q15(total);
          r.zero_sum    = (total == 0);
          r.last        = (i == k - 1);
          prev_msg[i]   = r.fwd_prob;
          expected_msgs.push_back(r);
        end
        msg_sum = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [Q15_W-1:0] want,
                                      input logic [Q15_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(input fwd_result_t got);
    fwd_result_t want;
    if (expected_msgs.size() == 0) begin
      $display("%0t: result item with none expected, state %0d fwd_prob %0d",
               $time, got.state_index, got.fwd_prob);
      mismatches++;
      return;
    end
    want = expected_msgs.pop_front();
    check_field("state_index", Q15_W'(want.state_index), Q15_W'(got.state_index));
    check_field("fwd_prob", want.fwd_prob, got.fwd_prob);
    check_field("marg_prob", want.marg_prob, got.marg_prob);
    check_field("zero_sum", Q15_W'(want.zero_sum), Q15_W'(got.zero_sum));
    check_field("last", Q15_W'(want.last), Q15_W'(got.last));
  endfunction

  // inputs are handled before outputs so a same-edge closing item is never missed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (init_prob[i]) init_prob[i] = '0;
      foreach (trans_prob[i, j]) trans_prob[i][j] = '0;
      foreach (prev_msg[i]) prev_msg[i] = '0;
      foreach (pending_msg[i]) pending_msg[i] = '0;
      msg_sum = '0;
      num_states = NUM_STATES_RESET;
      expected_msgs.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == NUM_STATES_ADDR)
        num_states = pwdata[NUM_STATES_W-1:0];
      if (in_mon_i.valid && in_mon_i.ready)
        advance_forward(in_mon_i.op, in_mon_i.row_index, in_mon_i.col_index,
                        in_mon_i.value, in_mon_i.first_step);
      if (out_mon_i.valid && out_mon_i.ready)
        compare_result({out_mon_i.state_index, out_mon_i.fwd_prob, out_mon_i.marg_prob,
                        out_mon_i.zero_sum, out_mon_i.last});
    end
    error_count_o <= mismatches;
    outstanding_o <= expected_msgs.size();
  end

endmodule

// File: tb/hmm_forward_normalized_test.sv
// hmm_forward_normalized_test: drives load and evidence items and register writes into the
// scaled hmm forward block with random idling and back-pressure, then gives the verdict
// depends on hmmf_pkg, hmmf_in_if, hmmf_out_if, hmm_forward_normalized, hmmf_forward_checker

module hmm_forward_normalized_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hmmf_pkg::*;

  localparam int unsigned        MAX_STATES      = 16;
  localparam logic [PADDR_W-1:0] NUM_STATES_ADDR = PADDR_W'(4 * REG_NUM_STATES);
  // op code the block must ignore
  localparam logic [OP_W-1:0]    OP_UNUSED       = 2'd3;
  localparam int unsigned        CYCLE_LIMIT     = 1_000_000;
  // longest quiet time an item with no result may still be busy, plus margin
  localparam int unsigned        SETTLE_CYCLES   = 64;
  // one long receiver hold-off once this many results have been taken
  localparam int unsigned        PRESSURE_AT     = 40;
  localparam int unsigned        PRESSURE_HOLD   = 600;
  localparam int unsigned        PHASE_ITEMS     = 4;
  // low states whose transition entries are all loaded; wider steps run as first steps
  localparam int unsigned        TRANS_FILL      = 4;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned error_count;
  int unsigned outstanding;
  int unsigned cycle_count  = 0;
  // states in use as the block sees them, after clamping
  int unsigned active_k     = MAX_STATES;
  // items that do real work, ignored ones left out
  int unsigned useful_items = 0;
  // remaining items of a stretch without idling, one per side
  int unsigned send_calm    = 0;
  int unsigned take_calm    = 0;

  hmmf_in_if  item_in ();
  hmmf_out_if result_out ();

  hmm_forward_normalized #(
    .MAX_STATES(MAX_STATES)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_i  (item_in),
    .out_o (result_out)
  );

  hmmf_forward_checker #(
    .MAX_STATES      (MAX_STATES),
    .NUM_STATES_ADDR (NUM_STATES_ADDR)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .pready,
    .paddr,
    .pwdata,
    .in_mon_i      (item_in),
    .out_mon_i     (result_out),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog on a plain cycle count
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // random idle gap before the next item, with occasional stretches of none
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 9);
  endfunction

  // q1.15 values weighted toward the edges; raw 16-bit values exercise saturation
  function automatic logic [Q15_W-1:0] random_q15();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return '0;
    if (pick < 5) return Q15_ONE;
    if (pick < 8) return Q15_W'($urandom);
    return Q15_W'($urandom_range(0, 32768));
  endfunction

  // offer one item after a random gap and hold it until the block takes it;
  // valid stays high when the next item follows with no gap
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [Q15_W-1:0] value,
                           input logic first);
    int unsigned gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      item_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_in.valid      <= 1'b1;
    item_in.op         <= op;
    item_in.row_index  <= row;
    item_in.col_index  <= col;
    item_in.value      <= value;
    item_in.first_step <= first;
    @(posedge clk_i);
    while (!item_in.ready) @(posedge clk_i);
    if (!(op == OP_UNUSED || (op == OP_EVIDENCE && col >= active_k))) useful_items++;
  endtask

  // setup and access cycle; the register takes the value on the access edge
  task automatic write_num_states(input logic [NUM_STATES_W-1:0] k);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NUM_STATES_ADDR;
    pwdata  <= PDATA_W'(k);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // zero means one state, anything above the table means all of them
    active_k = (k == 0) ? 1 : (k > MAX_STATES) ? MAX_STATES : k;
  endtask

  // stop offering, wait for every expected result, then let in-flight
  // items that cause no result finish
  task automatic settle();
    item_in.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_load();
    if ($urandom_range(0, 1))
      send_item(OP_LOAD_TRANS, IDX_W'($urandom), IDX_W'($urandom), random_q15(),
                1'($urandom));
    else
      send_item(OP_LOAD_INIT, IDX_W'($urandom), IDX_W'($urandom), random_q15(),
                1'($urandom));
  endtask

  // one well-formed time step: evidence for states 0..k-1 in order,
  // now and then a table update slipped in between
  task automatic run_step(input int unsigned k, input logic first);
    for (int s = 0; s < k; s++) begin
      if ($urandom_range(0, 9) == 0) send_random_load();
      send_item(OP_EVIDENCE, IDX_W'($urandom), IDX_W'(s), random_q15(), first);
    end
  endtask

  // items the block must drop: unused op, or evidence past the states in use
  task automatic send_noise();
    if (active_k < MAX_STATES && $urandom_range(0, 1))
      send_item(OP_EVIDENCE, IDX_W'($urandom), IDX_W'($urandom_range(active_k, MAX_STATES - 1)),
                random_q15(), 1'($urandom));
    else
      send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), Q15_W'($urandom),
                1'($urandom));
  endtask

  // one register setting, then mostly well-formed steps with random content,
  // the rest loads, noise and broken steps
  task automatic random_phase(input logic [NUM_STATES_W-1:0] k_reg, input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    settle();
    write_num_states(k_reg);
    stop_at = useful_items + quota;
    while (useful_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        run_step(active_k, active_k > TRANS_FILL || $urandom_range(0, 3) == 0);
      end else if (pick < 75) begin
        send_random_load();
      end else if (pick < 88) begin
        send_noise();
      end else begin
        // broken step: random order, repeats, may or may not close
        n = $urandom_range(1, active_k);
        repeat (n)
          send_item(OP_EVIDENCE, IDX_W'($urandom), IDX_W'($urandom_range(0, active_k - 1)),
                    random_q15(), (active_k > TRANS_FILL) ? 1'b1 : 1'($urandom));
      end
    end
  endtask

  // drive the running sum into its 20-bit clip: many full-scale messages
  // for state 0 before the step closes
  task automatic flood_running_sum();
    send_item(OP_LOAD_INIT, IDX_W'($urandom), '0, Q15_ONE, 1'b0);
    repeat (34) send_item(OP_EVIDENCE, IDX_W'($urandom), '0, Q15_ONE, 1'b1);
    for (int s = 1; s < active_k; s++)
      send_item(OP_EVIDENCE, IDX_W'($urandom), IDX_W'(s), random_q15(), 1'b1);
  endtask

  // result side: random ready gaps, plus one long hold-off so the block
  // backs up into its input while items keep being offered
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          held;
    taken = 0;
    held  = 1'b0;
    result_out.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(take_calm);
      if (!held && taken >= PRESSURE_AT) begin
        gap  = PRESSURE_HOLD;
        held = 1'b1;
      end
      if (gap > 0) begin
        result_out.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_out.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_out.valid) @(posedge clk_i);
      taken++;
    end
  end

  // item side and verdict
  initial begin
    item_in.valid      <= 1'b0;
    item_in.op         <= OP_LOAD_INIT;
    item_in.row_index  <= '0;
    item_in.col_index  <= '0;
    item_in.value      <= '0;
    item_in.first_step <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all states in use while the stores are filled
    write_num_states(NUM_STATES_W'(MAX_STATES));

    // fill every initial entry and the transition entries among the low states;
    // steps over more states than those only ever run as first steps
    for (int c = 0; c < MAX_STATES; c++)
      send_item(OP_LOAD_INIT, IDX_W'($urandom), IDX_W'(c), random_q15(), 1'($urandom));
    for (int r = 0; r < TRANS_FILL; r++)
      for (int c = 0; c < TRANS_FILL; c++)
        send_item(OP_LOAD_TRANS, IDX_W'(r), IDX_W'(c), random_q15(), 1'($urandom));
    // a first step over all states gives every previous and pending message a value
    run_step(MAX_STATES, 1'b1);

    // directed part with four states
    settle();
    write_num_states(NUM_STATES_W'(4));
    // value above one saturates; zero and top table indexes
    send_item(OP_LOAD_INIT, '0, '0, 16'hFFFF, 1'b0);
    send_item(OP_LOAD_INIT, '1, '1, '0, 1'b1);
    send_item(OP_LOAD_TRANS, '1, '1, 16'hFFFF, 1'b0);
    send_item(OP_LOAD_TRANS, '0, IDX_W'(3), Q15_ONE, 1'b1);
    // unused op does nothing
    send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), Q15_W'($urandom), 1'b1);
    // evidence for a state past the ones in use is dropped
    send_item(OP_EVIDENCE, '0, IDX_W'(9), Q15_ONE, 1'b0);
    // first step, evidence at its extremes
    send_item(OP_EVIDENCE, '0, IDX_W'(0), Q15_ONE, 1'b1);
    send_item(OP_EVIDENCE, '0, IDX_W'(1), 16'hFFFF, 1'b1);
    send_item(OP_EVIDENCE, '0, IDX_W'(2), '0, 1'b1);
    send_item(OP_EVIDENCE, '0, IDX_W'(3), 16'd1, 1'b1);
    // zero evidence everywhere: zero sum, messages cleared
    for (int s = 0; s < 4; s++) send_item(OP_EVIDENCE, '1, IDX_W'(s), '0, 1'b1);
    // continuing from an all-zero message stays at zero sum
    for (int s = 0; s < 4; s++) send_item(OP_EVIDENCE, '1, IDX_W'(s), Q15_ONE, 1'b0);
    // out of order with a repeated state, closed by the last state
    send_item(OP_EVIDENCE, '0, IDX_W'(2), Q15_ONE, 1'b1);
    send_item(OP_EVIDENCE, '0, IDX_W'(0), 16'd12345, 1'b1);
    send_item(OP_EVIDENCE, '0, IDX_W'(2), 16'd777, 1'b1);
    send_item(OP_EVIDENCE, '0, IDX_W'(1), 16'd20000, 1'b1);
    send_item(OP_EVIDENCE, '0, IDX_W'(3), Q15_ONE, 1'b1);

    // random part over several settings, the extremes and the clamped
    // values zero and 31 among them
    random_phase(NUM_STATES_W'(1), PHASE_ITEMS);
    random_phase(NUM_STATES_W'(MAX_STATES), PHASE_ITEMS);
    random_phase('0, PHASE_ITEMS);
    random_phase('1, PHASE_ITEMS);
    random_phase(NUM_STATES_W'($urandom_range(2, MAX_STATES - 1)), PHASE_ITEMS);
    random_phase(NUM_STATES_W'(4), PHASE_ITEMS);
    flood_running_sum();
    random_phase(NUM_STATES_W'($urandom_range(2, MAX_STATES - 1)), PHASE_ITEMS);
    random_phase(NUM_STATES_W'(2), PHASE_ITEMS);

    // drain: every expected result in, then the quiet tail
    settle();
    if (error_count == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
